// ----- src/seven_segment_rotating_display_unit_assert.svh -----
// assertion macros for the rotating seven-segment display checker
// used by ssrd_checker; expects a signal named clk in the using scope
`ifndef SEVEN_SEGMENT_ROTATING_DISPLAY_UNIT_ASSERT_SVH
`define SEVEN_SEGMENT_ROTATING_DISPLAY_UNIT_ASSERT_SVH

// same-cycle implication, disabled while dis is high
`define SSRD_ASSERT_NOW(lbl, dis, a, b) \
  lbl: assert property (@(posedge clk) disable iff (dis) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication, disabled while dis is high
`define SSRD_ASSERT_NEXT(lbl, dis, a, b) \
  lbl: assert property (@(posedge clk) disable iff (dis) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ----- src/ssrd_pkg.sv -----
// shared types, constants and functions of the rotating seven-segment display
// no dependencies
`timescale 1ns / 1ps

package ssrd_pkg;

  localparam int NUM_DIGITS = 8;
  localparam int POS_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  localparam logic [7:0] SEG_OFF = 8'hff;

  localparam logic [4:0] BTN_CENTRE = 5'h01;
  localparam logic [4:0] BTN_LEFT   = 5'h04;
  localparam logic [4:0] BTN_RIGHT  = 5'h08;

  localparam logic REQ_BUTTON = 1'b0;
  localparam logic REQ_SCAN   = 1'b1;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_CENTRE,
    OP_LEFT,
    OP_RIGHT
  } op_t;

  typedef struct packed {
    logic en;
    op_t  op;
  } cell_ctrl_t;

  typedef struct packed {
    logic [7:0] digit_select;
    logic [7:0] segment_pattern;
  } res_t;

  localparam logic [7:0] HEX_FONT [16] = '{
    8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8,
    8'h80, 8'h90, 8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e
  };

  function automatic op_t decode_buttons(input logic [4:0] buttons);
    op_t op;
    priority if ((buttons & BTN_CENTRE) != 5'd0) op = OP_CENTRE;
    else if ((buttons & BTN_LEFT) != 5'd0)       op = OP_LEFT;
    else if ((buttons & BTN_RIGHT) != 5'd0)      op = OP_RIGHT;
    else                                         op = OP_NONE;
    return op;
  endfunction

  // digits 8 and up have no enable line
  function automatic logic [7:0] digit_enable(input logic [POS_W-1:0] pos);
    logic [7:0] sel;
    for (int k = 0; k < 8; k++) begin
      sel[7-k] = !(32'(pos) == k);
    end
    return sel;
  endfunction

endpackage

// ----- src/ssrd_if.sv -----
// handshake interfaces for request and result items
// depends on ssrd_pkg
`timescale 1ns / 1ps

interface ssrd_req_if import ssrd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [4:0] buttons;
  logic [3:0] switch_nibble;

  modport source (output valid, output req_type, output buttons, output switch_nibble,
                  input ready);
  modport sink   (input valid, input req_type, input buttons, input switch_nibble,
                  output ready);
endinterface

interface ssrd_res_if import ssrd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] digit_select;
  logic [7:0] segment_pattern;

  modport source (output valid, output digit_select, output segment_pattern,
                  input ready);
  modport sink   (input valid, input digit_select, input segment_pattern,
                  output ready);
endinterface

// ----- src/ssrd_cell.sv -----
// one digit of the segment buffer, linked to both neighbours for rotation
// depends on ssrd_pkg
`timescale 1ns / 1ps

module ssrd_cell import ssrd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] load_byte,
  input  logic [7:0] from_left,
  input  logic [7:0] from_right,
  output logic [7:0] seg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      seg <= SEG_OFF;
    end else if (ctrl.en) begin
      unique case (ctrl.op)
        OP_CENTRE: seg <= load_byte;
        OP_LEFT:   seg <= from_right;
        OP_RIGHT:  seg <= from_left;
        OP_NONE:   seg <= seg;
        default:   seg <= seg;
      endcase
    end
  end

endmodule

// ----- src/ssrd_outq.sv -----
// two-entry result queue between the scan logic and the result channel
// depends on ssrd_pkg
`timescale 1ns / 1ps

module ssrd_outq import ssrd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  res_t  din,
  output logic  full,
  ssrd_res_if.source res
);

  res_t       head;
  res_t       tail;
  logic [1:0] count;
  logic       pop;

  assign pop                 = res.valid && res.ready;
  assign full                = (count == 2'd2);
  assign res.valid           = (count != 2'd0);
  assign res.digit_select    = head.digit_select;
  assign res.segment_pattern = head.segment_pattern;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      priority case ({push, pop})
        2'b11: begin
          if (count == 2'd1) begin
            head <= din;
          end else begin
            head <= tail;
            tail <= din;
          end
        end
        2'b01: begin
          head  <= tail;
          count <= count - 2'd1;
        end
        2'b10: begin
          if (count == 2'd0) head <= din;
          else               tail <= din;
          count <= count + 2'd1;
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

endmodule

// ----- src/seven_segment_rotating_display_unit.sv -----
// Rotating seven-segment display driver: takes one item per clock cycle while ready
// is high, button events and scan ticks alike. The segment buffer is a row of digit
// cells that update together in the cycle a button event is accepted, whether for a
// rotation or a centre load. A scan tick reads the current digit and pushes its result
// into a two-entry output queue in the same cycle; ready falls only while both queue
// slots hold results that have not been taken. No clearing pass after reset: the
// buffer comes up all off.
// depends on ssrd_pkg, ssrd_if, ssrd_cell and ssrd_outq
`timescale 1ns / 1ps

module seven_segment_rotating_display_unit import ssrd_pkg::*; (
  input  logic clk,
  input  logic rst,
  ssrd_req_if.sink   req,
  ssrd_res_if.source res
);

  logic [7:0]       seg [NUM_DIGITS];
  logic [POS_W-1:0] pos;
  logic             full;
  logic             accept;
  logic             scan;
  cell_ctrl_t       ctrl;
  res_t             din;

  assign req.ready = !full;
  assign accept    = req.valid && req.ready;
  assign scan      = accept && (req.req_type == REQ_SCAN);
  assign ctrl.en   = accept && (req.req_type == REQ_BUTTON);
  assign ctrl.op   = decode_buttons(req.buttons);

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    ssrd_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .load_byte  ((i == NUM_DIGITS - 1) ? HEX_FONT[req.switch_nibble] : SEG_OFF),
      .from_left  (seg[(i + NUM_DIGITS - 1) % NUM_DIGITS]),
      .from_right (seg[(i + 1) % NUM_DIGITS]),
      .seg        (seg[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (scan) begin
      pos <= (pos == POS_W'(NUM_DIGITS - 1)) ? '0 : pos + POS_W'(1);
    end
  end

  assign din.digit_select    = digit_enable(pos);
  assign din.segment_pattern = seg[pos];

  ssrd_outq u_outq (
    .clk  (clk),
    .rst  (rst),
    .push (scan),
    .din  (din),
    .full (full),
    .res  (res)
  );

endmodule

// ----- src/ssrd_checker.sv -----
// port-level checks on the rotating seven-segment display, bound to the top level
// depends on seven_segment_rotating_display_unit_assert.svh
`timescale 1ns / 1ps
`include "seven_segment_rotating_display_unit_assert.svh"

module ssrd_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       req_type,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] digit_select
);

  `SSRD_ASSERT_NEXT(a_reset_empty, 1'b0, rst, !res_valid)
  `SSRD_ASSERT_NEXT(a_res_holds, rst, res_valid && !res_ready, res_valid)
  `SSRD_ASSERT_NEXT(a_scan_shows, rst, req_valid && req_ready && req_type && !res_valid, res_valid)
  `SSRD_ASSERT_NOW(a_one_digit, rst, res_valid, $countones(~digit_select) <= 1)

endmodule

bind seven_segment_rotating_display_unit ssrd_checker u_ssrd_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_type     (req.req_type),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .digit_select (res.digit_select)
);

// ----- bench/seven_segment_rotating_display_unit_tb.sv -----
// testbench for the rotating seven-segment display: drives button and scan items,
// predicts each digit readout and checks it against the result channel
// depends on ssrd_pkg, ssrd_if and seven_segment_rotating_display_unit
`timescale 1ns / 1ps

module seven_segment_rotating_display_unit_tb;
  import ssrd_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 20;

  localparam logic [7:0] SEG_FONT [16] = '{
    8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8,
    8'h80, 8'h90, 8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e
  };

  logic clk;
  logic rst;

  ssrd_req_if req_ch ();
  ssrd_res_if res_ch ();

  seven_segment_rotating_display_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  logic [7:0] seg_buf [NUM_DIGITS];
  int         scan_pos;
  res_t       expected_readouts [$];
  int         mismatch_count;
  int         cycle_count;
  int         send_calm;
  int         recv_calm;
  int         recv_stall;
  bit         draining;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic apply_request(input logic rtype, input logic [4:0] btn,
                               input logic [3:0] nib);
    op_t        op;
    res_t       r;
    logic [7:0] held;
    int         k;
    if (rtype == REQ_SCAN) begin
      r.digit_select    = (scan_pos < 8) ? ~(8'h80 >> scan_pos) : 8'hff;
      r.segment_pattern = seg_buf[scan_pos];
      expected_readouts.push_back(r);
      scan_pos = (scan_pos == NUM_DIGITS - 1) ? 0 : scan_pos + 1;
    end else begin
      if ((btn & BTN_CENTRE) != 5'd0) op = OP_CENTRE;
      else if ((btn & BTN_LEFT) != 5'd0) op = OP_LEFT;
      else if ((btn & BTN_RIGHT) != 5'd0) op = OP_RIGHT;
      else op = OP_NONE;
      case (op)
        OP_CENTRE: begin
          for (k = 0; k < NUM_DIGITS - 1; k++) seg_buf[k] = SEG_OFF;
          seg_buf[NUM_DIGITS - 1] = SEG_FONT[nib];
        end
        OP_LEFT: begin
          held = seg_buf[0];
          for (k = 0; k < NUM_DIGITS - 1; k++) seg_buf[k] = seg_buf[k + 1];
          seg_buf[NUM_DIGITS - 1] = held;
        end
        OP_RIGHT: begin
          held = seg_buf[NUM_DIGITS - 1];
          for (k = NUM_DIGITS - 1; k > 0; k--) seg_buf[k] = seg_buf[k - 1];
          seg_buf[0] = held;
        end
        default: ;
      endcase
    end
  endtask

  // called just after a falling edge; returns just after a later falling edge, once the item has been accepted
  task automatic send_item(input logic rtype, input logic [4:0] btn, input logic [3:0] nib);
    int gap;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 29) == 0) send_calm = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= rtype;
    req_ch.buttons       <= btn;
    req_ch.switch_nibble <= nib;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    apply_request(rtype, btn, nib);
    @(negedge clk);
  endtask

  initial begin
    res_ch.ready = 1'b0;
    recv_stall   = 0;
    recv_calm    = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (recv_stall > 0 && !draining) begin
        res_ch.ready <= 1'b0;
        recv_stall--;
      end else begin
        res_ch.ready <= 1'b1;
        if (recv_calm > 0) begin
          recv_calm--;
        end else begin
          recv_stall = pick_gap();
          if ($urandom_range(0, 29) == 0) recv_calm = $urandom_range(20, 60);
        end
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (expected_readouts.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual select %h segments %h",
                 $time, res_ch.digit_select, res_ch.segment_pattern);
        mismatch_count++;
      end else begin
        want = expected_readouts.pop_front();
        if (res_ch.digit_select !== want.digit_select) begin
          $display("%0t: digit_select expected %h actual %h",
                   $time, want.digit_select, res_ch.digit_select);
          mismatch_count++;
        end
        if (res_ch.segment_pattern !== want.segment_pattern) begin
          $display("%0t: segment_pattern expected %h actual %h",
                   $time, want.segment_pattern, res_ch.segment_pattern);
          mismatch_count++;
        end
      end
    end
  end

  task automatic scan_digits(input int count);
    int k;
    for (k = 0; k < count; k++) send_item(REQ_SCAN, 5'($urandom), 4'($urandom));
  endtask

  task automatic test_blank_readout();
    send_item(REQ_SCAN, 5'h00, 4'h0);
    send_item(REQ_SCAN, 5'h1f, 4'hf);
    send_item(REQ_SCAN, 5'h01, 4'h0);
  endtask

  task automatic test_centre_load();
    // all buttons at once, centre wins
    send_item(REQ_BUTTON, 5'h1f, 4'hf);
    scan_digits(5);
    send_item(REQ_BUTTON, BTN_CENTRE, 4'h0);
  endtask

  task automatic test_rotate_priority();
    // left wins over right
    send_item(REQ_BUTTON, BTN_LEFT | BTN_RIGHT, 4'h5);
    send_item(REQ_BUTTON, BTN_RIGHT, 4'ha);
    send_item(REQ_BUTTON, BTN_RIGHT, 4'h0);
    scan_digits(2);
    send_item(REQ_BUTTON, BTN_LEFT, 4'hf);
  endtask

  task automatic test_ignored_buttons();
    send_item(REQ_BUTTON, 5'h00, 4'hf);
    send_item(REQ_BUTTON, 5'h02, 4'h3);
    send_item(REQ_BUTTON, 5'h10, 4'hc);
    send_item(REQ_BUTTON, 5'h12, 4'h9);
    scan_digits(8);
  endtask

  task automatic test_random_traffic(input int count);
    int         k;
    int         r;
    logic [4:0] btn;
    for (k = 0; k < count; k++) begin
      r   = $urandom_range(0, 99);
      btn = 5'($urandom);
      if (r < 45) begin
        send_item(REQ_SCAN, btn, 4'($urandom));
      end else if (r < 55) begin
        send_item(REQ_BUTTON, btn | BTN_CENTRE, 4'($urandom));
      end else if (r < 72) begin
        send_item(REQ_BUTTON, (btn & 5'b11010) | BTN_LEFT, 4'($urandom));
      end else if (r < 89) begin
        send_item(REQ_BUTTON, (btn & 5'b10010) | BTN_RIGHT, 4'($urandom));
      end else if (r < 95) begin
        send_item(REQ_BUTTON, btn & 5'b10010, 4'($urandom));
      end else begin
        send_item(REQ_BUTTON, btn, 4'($urandom));
      end
    end
  endtask

  initial begin
    int k;
    for (k = 0; k < NUM_DIGITS; k++) seg_buf[k] = SEG_OFF;
    scan_pos             = 0;
    mismatch_count       = 0;
    cycle_count          = 0;
    send_calm            = 0;
    draining             = 1'b0;
    rst                  = 1'b1;
    req_ch.valid         = 1'b0;
    req_ch.req_type      = REQ_BUTTON;
    req_ch.buttons       = 5'd0;
    req_ch.switch_nibble = 4'd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_blank_readout();
    test_centre_load();
    test_rotate_priority();
    test_ignored_buttons();
    test_random_traffic(600);

    req_ch.valid <= 1'b0;
    draining = 1'b1;
    while (expected_readouts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/ssrd_pkg.sv
src/ssrd_if.sv
src/ssrd_cell.sv
src/ssrd_outq.sv
src/seven_segment_rotating_display_unit.sv
src/ssrd_checker.sv
bench/seven_segment_rotating_display_unit_tb.sv
